// ===== hdl/ngp_pkg.sv =====
// Shared types and constants for the NMEA GLL position parser.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package ngp_pkg;

  localparam int BYTE_W    = 8;
  localparam int LAT_W     = 30;
  localparam int LON_W     = 34;
  localparam int LAT_SLOTS = 8;
  localparam int LON_SLOTS = 9;
  localparam int POS_W     = 4;
  localparam int DIGIT_W   = 4;
  localparam int MIN_W     = 20;   // six decimal minute digits, at most 999999
  localparam int SCL_W     = 26;   // minutes times 50, at most 49999950
  localparam int QUO_W     = 24;   // scaled minutes divided by three
  localparam int PROD_W    = 52;
  localparam int RCP_SHIFT = 27;

  localparam logic [BYTE_W-1:0] CH_L     = 8'h4C;
  localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

  // Ceiling of 2^27 / 3; exact floor division by three for values below 2^27.
  localparam logic [SCL_W-1:0] RECIP3   = 26'd44739243;
  localparam logic [LAT_W-1:0] E7_LAT   = 30'd10000000;
  localparam logic [LON_W-1:0] E7_LON   = 34'd10000000;
  localparam logic [LAT_W-1:0] LAT_MAX  = 30'd1006666650;
  localparam logic [LON_W-1:0] LON_MAX  = 34'd10006666650;

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_L2     = 3'd1,
    PH_COMMA  = 3'd2,
    PH_LAT    = 3'd3,
    PH_LATDIR = 3'd4,
    PH_LON    = 3'd5,
    PH_OUT    = 3'd6
  } phase_t;

endpackage

`default_nettype wire

// ===== hdl/ngp_if.sv =====
// Handshake channels of the NMEA GLL position parser: byte input and position result.
// Depends on ngp_pkg for the payload widths.
`timescale 1ns / 1ps
`default_nettype none

interface ngp_byte_if;
  import ngp_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ngp_pos_if;
  import ngp_pkg::*;
  logic             valid;
  logic             ready;
  logic [LAT_W-1:0] latitude_e7;
  logic [LON_W-1:0] longitude_e7;
  modport source (output valid, output latitude_e7, output longitude_e7, input ready);
  modport sink   (input valid, input latitude_e7, input longitude_e7, output ready);
endinterface

`default_nettype wire

// ===== hdl/nmea_gll_position_parser.sv =====
// Each byte taken in the field after the longitude, its comma too, gives a result. One byte per
// cycle is taken unless out_ch back-pressure fills the pipeline; digits are stored as taken and the
// conversion runs in a four-register pipeline (minute sum, scaling, reciprocal multiply, add).
// Reset: synchronous, active low; clears the parse phase, the digit stores, the write
// positions and the pipeline valid flags. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module nmea_gll_position_parser (
  input  wire logic clk,
  input  wire logic rst_n,
  ngp_byte_if.sink  in_ch,
  ngp_pos_if.source out_ch
);
  import ngp_pkg::*;

  function automatic logic [MIN_W-1:0] six_dig(input logic [6*DIGIT_W-1:0] d);
    logic [MIN_W-1:0] m;
    m = '0;
    for (int i = 0; i < 6; i++) begin
      m = MIN_W'(m * MIN_W'(10)) + MIN_W'(d[i*DIGIT_W +: DIGIT_W]);
    end
    return m;
  endfunction

  // Parser state.
  phase_t             phase_r, phase_nxt;
  logic [DIGIT_W-1:0] lat_dig_r [LAT_SLOTS];
  logic [DIGIT_W-1:0] lon_dig_r [LON_SLOTS];
  logic [POS_W-1:0]   lat_pos_r, lat_pos_nxt;
  logic [POS_W-1:0]   lon_pos_r, lon_pos_nxt;

  logic               accept;
  logic               is_comma, is_digit;
  logic               lat_we, lon_we, emit;
  logic [DIGIT_W-1:0] digit;

  // Pipeline.
  logic               rdy1, rdy2, rdy3, adv_o;
  logic               s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic [MIN_W-1:0]   s1_lat_min_r, s1_lon_min_r;
  logic [6:0]         s1_lat_deg_r;
  logic [9:0]         s1_lon_deg_r;
  logic [SCL_W-1:0]   s2_lat_scl_r, s2_lon_scl_r;
  logic [LAT_W-1:0]   s2_lat_deg_r, s3_lat_deg_r;
  logic [LON_W-1:0]   s2_lon_deg_r, s3_lon_deg_r;
  logic [PROD_W-1:0]  lat_prod, lon_prod;
  logic [QUO_W-1:0]   s3_lat_quo_r, s3_lon_quo_r;
  logic [LAT_W-1:0]   out_lat_r;
  logic [LON_W-1:0]   out_lon_r;
  logic [6*DIGIT_W-1:0] lat_min_dig, lon_min_dig;

  assign adv_o = !out_v_r || out_ch.ready;
  assign rdy3  = !s3_v_r || adv_o;
  assign rdy2  = !s2_v_r || rdy3;
  assign rdy1  = !s1_v_r || rdy2;

  assign in_ch.ready = rdy1;
  assign accept      = in_ch.valid && rdy1;
  assign is_comma    = (in_ch.rx_byte == CH_COMMA);
  assign is_digit    = (in_ch.rx_byte inside {[CH_ZERO:CH_NINE]});
  assign digit       = in_ch.rx_byte[DIGIT_W-1:0];

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_HUNT:   phase_nxt = (in_ch.rx_byte == CH_L) ? PH_L2 : PH_HUNT;
      PH_L2:     phase_nxt = (in_ch.rx_byte == CH_L) ? PH_COMMA : PH_HUNT;
      PH_COMMA:  phase_nxt = is_comma ? PH_LAT : PH_HUNT;
      PH_LAT:    phase_nxt = is_comma ? PH_LATDIR : PH_LAT;
      PH_LATDIR: phase_nxt = is_comma ? PH_LON : PH_LATDIR;
      PH_LON:    phase_nxt = is_comma ? PH_OUT : PH_LON;
      PH_OUT:    phase_nxt = is_comma ? PH_HUNT : PH_OUT;
      default:   phase_nxt = (in_ch.rx_byte == CH_L) ? PH_L2 : PH_HUNT;
    endcase
  end

  // Actions of each phase.
  always_comb begin
    lat_we      = 1'b0;
    lon_we      = 1'b0;
    emit        = 1'b0;
    lat_pos_nxt = lat_pos_r;
    lon_pos_nxt = lon_pos_r;
    case (phase_r)
      PH_LAT: begin
        lat_we = accept && !is_comma && is_digit && (lat_pos_r < POS_W'(LAT_SLOTS));
        if (lat_we) lat_pos_nxt = lat_pos_r + 1'b1;
      end
      PH_LON: begin
        lon_we = accept && !is_comma && is_digit && (lon_pos_r < POS_W'(LON_SLOTS));
        if (lon_we) lon_pos_nxt = lon_pos_r + 1'b1;
      end
      PH_OUT: begin
        emit = accept;
        if (accept) begin
          lat_pos_nxt = '0;
          lon_pos_nxt = '0;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      lat_pos_r <= '0;
      lon_pos_r <= '0;
      for (int i = 0; i < LAT_SLOTS; i++) lat_dig_r[i] <= '0;
      for (int i = 0; i < LON_SLOTS; i++) lon_dig_r[i] <= '0;
    end else begin
      if (accept) phase_r <= phase_nxt;
      lat_pos_r <= lat_pos_nxt;
      lon_pos_r <= lon_pos_nxt;
      for (int i = 0; i < LAT_SLOTS; i++) begin
        if (lat_we && lat_pos_r == POS_W'(i)) lat_dig_r[i] <= digit;
      end
      for (int i = 0; i < LON_SLOTS; i++) begin
        if (lon_we && lon_pos_r == POS_W'(i)) lon_dig_r[i] <= digit;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      lat_min_dig[i*DIGIT_W +: DIGIT_W] = lat_dig_r[2 + i];
      lon_min_dig[i*DIGIT_W +: DIGIT_W] = lon_dig_r[3 + i];
    end
  end

  assign lat_prod = PROD_W'(s2_lat_scl_r) * PROD_W'(RECIP3);
  assign lon_prod = PROD_W'(s2_lon_scl_r) * PROD_W'(RECIP3);

  // Pipeline valid flags; a stage takes new contents whenever it is empty or moving on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (rdy1)  s1_v_r  <= emit;
      if (rdy2)  s2_v_r  <= s1_v_r;
      if (rdy3)  s3_v_r  <= s2_v_r;
      if (adv_o) out_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      s1_lat_min_r <= six_dig(lat_min_dig);
      s1_lon_min_r <= six_dig(lon_min_dig);
      s1_lat_deg_r <= 7'(lat_dig_r[0]) * 7'd10 + 7'(lat_dig_r[1]);
      s1_lon_deg_r <= 10'(lon_dig_r[0]) * 10'd100 + 10'(lon_dig_r[1]) * 10'd10
                    + 10'(lon_dig_r[2]);
    end
    if (rdy2 && s1_v_r) begin
      s2_lat_scl_r <= SCL_W'(s1_lat_min_r) * SCL_W'(50);
      s2_lon_scl_r <= SCL_W'(s1_lon_min_r) * SCL_W'(50);
      s2_lat_deg_r <= LAT_W'(s1_lat_deg_r) * E7_LAT;
      s2_lon_deg_r <= LON_W'(s1_lon_deg_r) * E7_LON;
    end
    if (rdy3 && s2_v_r) begin
      s3_lat_quo_r <= lat_prod[RCP_SHIFT +: QUO_W];
      s3_lon_quo_r <= lon_prod[RCP_SHIFT +: QUO_W];
      s3_lat_deg_r <= s2_lat_deg_r;
      s3_lon_deg_r <= s2_lon_deg_r;
    end
    if (adv_o && s3_v_r) begin
      out_lat_r <= s3_lat_deg_r + LAT_W'(s3_lat_quo_r);
      out_lon_r <= s3_lon_deg_r + LON_W'(s3_lon_quo_r);
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.latitude_e7  = out_lat_r;
  assign out_ch.longitude_e7 = out_lon_r;

endmodule

`default_nettype wire

// ===== hdl/ngp_checker.sv =====
// Port-level checks for the NMEA GLL position parser, attached by bind.
// Depends on ngp_pkg and on the top level nmea_gll_position_parser.
`timescale 1ns / 1ps
`default_nettype none

module ngp_checker (
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    in_valid,
  input wire logic                    in_ready,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic [ngp_pkg::LAT_W-1:0] latitude_e7,
  input wire logic [ngp_pkg::LON_W-1:0] longitude_e7
);
  import ngp_pkg::*;

  // No result can be pending straight after reset.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result request shown right after reset");

  // A request that is not taken keeps its position.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && !out_ready |=> out_valid && $stable(latitude_e7) && $stable(longitude_e7))
    else $error("stalled result request changed");

  a_lat_range: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid |-> latitude_e7 <= LAT_MAX)
    else $error("latitude beyond largest encodable value");

  a_lon_range: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid |-> longitude_e7 <= LON_MAX)
    else $error("longitude beyond largest encodable value");

  // The input side is held off only while the pipeline holds work.
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
      !out_valid && !$past(in_valid && in_ready) |-> in_ready || $past(in_valid))
    else $error("input held off with nothing in flight");

endmodule

bind nmea_gll_position_parser ngp_checker u_ngp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .latitude_e7  (out_ch.latitude_e7),
  .longitude_e7 (out_ch.longitude_e7)
);

`default_nettype wire
